[design/hostname_or_ipv4_validator_macros.svh]
// Assertion macros for the host string validator.
// Used by hostname_or_ipv4_validator; expects clk and rst_n in scope.
`ifndef HOSTNAME_OR_IPV4_VALIDATOR_MACROS_SVH
`define HOSTNAME_OR_IPV4_VALIDATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HIV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HIV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/hiv_pkg.sv]
// Shared constants and character class helpers for the host string validator.
// No dependencies; imported by hiv_char_if, the top level and the testbench.
package hiv_pkg;

    localparam int CHAR_W         = 8;
    localparam int HOST_LEN_W     = 10;
    localparam int LABEL_LEN_W    = 7;
    localparam int DOT_CNT_W      = 3;
    localparam int OCTET_VAL_W    = 10;
    localparam int OCTET_DIG_W    = 3;
    localparam int OCTET_PROD_W   = 14;

    localparam logic [LABEL_LEN_W-1:0] LABEL_LIMIT      = 7'd63;
    localparam logic [OCTET_VAL_W-1:0] OCTET_MAX        = 10'd255;
    localparam logic [OCTET_DIG_W-1:0] OCTET_DIGITS_MAX = 3'd3;
    localparam logic [DOT_CNT_W-1:0]   QUAD_DOTS        = 3'd3;
    localparam logic [HOST_LEN_W-1:0]  MAX_LEN_RESET    = 10'd253;

    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return is_digit(c)
            || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

[design/hiv_if.sv]
// Valid/ready channel interfaces for the host string validator.
// Depends on hiv_pkg for field widths.
interface hiv_char_if
    import hiv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface hiv_verdict_if;
    logic valid;
    logic ready;
    logic host_valid;
    logic numeric_form;

    modport source (output valid, output host_valid, output numeric_form, input ready);
    modport sink   (input valid, input host_valid, input numeric_form, output ready);
endinterface

[design/hostname_or_ipv4_validator.sv]
// Host name / dotted-quad validator, one character word per clock.
// Depends on hiv_pkg, hiv_if.sv and hostname_or_ipv4_validator_macros.svh.
//
// Usage: the host string arrives on "chars", one byte per word, followed by
// a word with end_of_string set whose char_code is ignored. Only that end word
// produces a word on "verdict": host_valid and numeric_form (string held only
// digits and dots). The length limit is written through cfg_wr_en/cfg_wr_data
// while the block is idle, which is up to the user: the block does not
// enforce it. The limit resets to 253.
// Throughput: one word per clock, sustained; the input register feeds a single
// pass of compare and small add logic that updates the per-string counters.
// When verdict is stalled, a pending verdict waits in the output register and
// character words keep flowing; only a second end word waits in the input
// register, and then chars.ready drops until the verdict is taken.
// Reset clears all string state and empties both registers; the length
// limit returns to 253.
`include "hostname_or_ipv4_validator_macros.svh"

module hostname_or_ipv4_validator
    import hiv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hiv_char_if.sink              chars,
    hiv_verdict_if.source         verdict,
    input  logic                  cfg_wr_en,
    input  logic [HOST_LEN_W-1:0] cfg_wr_data
);

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_end_reg;

    // Per-string state.
    logic [HOST_LEN_W-1:0]  max_len_reg;
    logic [HOST_LEN_W-1:0]  char_count_reg,   char_count_next;
    logic [CHAR_W-1:0]      prev_char_reg,    prev_char_next;
    logic                   chars_ok_reg,     chars_ok_next;
    logic                   digits_dots_reg,  digits_dots_next;
    logic [LABEL_LEN_W-1:0] label_chars_reg,  label_chars_next;
    logic                   labels_ok_reg,    labels_ok_next;
    logic [DOT_CNT_W-1:0]   dot_count_reg,    dot_count_next;
    logic [OCTET_VAL_W-1:0] octet_val_reg,    octet_val_next;
    logic [OCTET_DIG_W-1:0] octet_dig_reg,    octet_dig_next;
    logic                   octets_ok_reg,    octets_ok_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic host_valid_reg, host_valid_next;
    logic numeric_reg, numeric_next;

    logic proc_char;
    logic proc_end;
    logic advance;
    logic label_fine;
    logic octet_fine;
    logic ok_common;
    logic [OCTET_PROD_W-1:0] octet_prod;

    // An end word can only move on when the output register is free or its verdict is taken in the same cycle.
    assign advance   = in_valid_reg && (!in_end_reg || !out_valid_reg || verdict.ready);
    assign proc_char = advance && !in_end_reg;
    assign proc_end  = advance && in_end_reg;

    assign chars.ready   = !in_valid_reg || advance;
    assign in_valid_next = chars.valid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    assign label_fine = (label_chars_reg != '0) && (label_chars_reg <= LABEL_LIMIT)
                        && is_alnum(prev_char_reg);
    assign octet_fine = (octet_dig_reg != '0) && (octet_dig_reg <= OCTET_DIGITS_MAX)
                        && (octet_val_reg <= OCTET_MAX);

    // value * 10 + digit, as two shifts and two adds.
    assign octet_prod = ({{(OCTET_PROD_W-OCTET_VAL_W){1'b0}}, octet_val_reg} << 3)
                      + ({{(OCTET_PROD_W-OCTET_VAL_W){1'b0}}, octet_val_reg} << 1)
                      + {{(OCTET_PROD_W-CHAR_W){1'b0}}, (in_char_reg - CHAR_ZERO)};

    assign ok_common = (char_count_reg != '0) && (char_count_reg <= max_len_reg)
                       && chars_ok_reg && (prev_char_reg != CHAR_DOT);

    always_comb
    begin
        char_count_next  = char_count_reg;
        prev_char_next   = prev_char_reg;
        chars_ok_next    = chars_ok_reg;
        digits_dots_next = digits_dots_reg;
        label_chars_next = label_chars_reg;
        labels_ok_next   = labels_ok_reg;
        dot_count_next   = dot_count_reg;
        octet_val_next   = octet_val_reg;
        octet_dig_next   = octet_dig_reg;
        octets_ok_next   = octets_ok_reg;
        host_valid_next  = host_valid_reg;
        numeric_next     = numeric_reg;
        out_valid_next   = (out_valid_reg && !verdict.ready) || proc_end;

        if (proc_end)
        begin
            if (digits_dots_reg)
            begin
                host_valid_next = ok_common && octets_ok_reg && octet_fine
                                  && (dot_count_reg == QUAD_DOTS);
            end
            else
            begin
                host_valid_next = ok_common && labels_ok_reg && label_fine;
            end
            numeric_next     = digits_dots_reg;
            char_count_next  = '0;
            prev_char_next   = '0;
            chars_ok_next    = 1'b1;
            digits_dots_next = 1'b1;
            label_chars_next = '0;
            labels_ok_next   = 1'b1;
            dot_count_next   = '0;
            octet_val_next   = '0;
            octet_dig_next   = '0;
            octets_ok_next   = 1'b1;
        end
        else if (proc_char)
        begin
            if (!is_alnum(in_char_reg) && in_char_reg != CHAR_HYPHEN
                && in_char_reg != CHAR_DOT)
            begin
                chars_ok_next = 1'b0;
            end
            if (char_count_reg == '0 && (in_char_reg == CHAR_HYPHEN
                || in_char_reg == CHAR_DOT))
            begin
                chars_ok_next = 1'b0;
            end
            if (&char_count_reg)
            begin
                chars_ok_next = 1'b0;
            end
            else
            begin
                char_count_next = char_count_reg + 1'b1;
            end
            if (!is_digit(in_char_reg) && in_char_reg != CHAR_DOT)
            begin
                digits_dots_next = 1'b0;
            end

            if (in_char_reg == CHAR_DOT)
            begin
                if (!label_fine)
                begin
                    labels_ok_next = 1'b0;
                end
                if (!octet_fine)
                begin
                    octets_ok_next = 1'b0;
                end
                label_chars_next = '0;
                octet_val_next   = '0;
                octet_dig_next   = '0;
                if (!(&dot_count_reg))
                begin
                    dot_count_next = dot_count_reg + 1'b1;
                end
            end
            else
            begin
                if (label_chars_reg == '0 && !is_alnum(in_char_reg))
                begin
                    labels_ok_next = 1'b0;
                end
                if (&label_chars_reg)
                begin
                    labels_ok_next = 1'b0;
                end
                else
                begin
                    label_chars_next = label_chars_reg + 1'b1;
                end
                if (is_digit(in_char_reg))
                begin
                    if (octet_prod > {{(OCTET_PROD_W-OCTET_VAL_W){1'b0}}, {OCTET_VAL_W{1'b1}}})
                    begin
                        octet_val_next = '1;
                    end
                    else
                    begin
                        octet_val_next = octet_prod[OCTET_VAL_W-1:0];
                    end
                    if (!(&octet_dig_reg))
                    begin
                        octet_dig_next = octet_dig_reg + 1'b1;
                    end
                end
            end
            prev_char_next = in_char_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            max_len_reg     <= MAX_LEN_RESET;
            char_count_reg  <= '0;
            prev_char_reg   <= '0;
            chars_ok_reg    <= 1'b1;
            digits_dots_reg <= 1'b1;
            label_chars_reg <= '0;
            labels_ok_reg   <= 1'b1;
            dot_count_reg   <= '0;
            octet_val_reg   <= '0;
            octet_dig_reg   <= '0;
            octets_ok_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            char_count_reg  <= char_count_next;
            prev_char_reg   <= prev_char_next;
            chars_ok_reg    <= chars_ok_next;
            digits_dots_reg <= digits_dots_next;
            label_chars_reg <= label_chars_next;
            labels_ok_reg   <= labels_ok_next;
            dot_count_reg   <= dot_count_next;
            octet_val_reg   <= octet_val_next;
            octet_dig_reg   <= octet_dig_next;
            octets_ok_reg   <= octets_ok_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_char_reg <= chars.char_code;
            in_end_reg  <= chars.end_of_string;
        end
        host_valid_reg <= host_valid_next;
        numeric_reg    <= numeric_next;
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.host_valid   = host_valid_reg;
    assign verdict.numeric_form = numeric_reg;

    `HIV_ASSERT_NEXT(a_clear_after_end, proc_end,
        char_count_reg == '0 && dot_count_reg == '0 && label_chars_reg == '0,
        "string state not cleared after end word")
    `HIV_ASSERT_SAME(a_verdict_from_end, $rose(out_valid_reg), $past(proc_end),
        "verdict appeared without an end word")
    `HIV_ASSERT_SAME(a_end_blocks_input,
        in_valid_reg && in_end_reg && out_valid_reg && !verdict.ready,
        !chars.ready && !proc_end,
        "end word advanced while verdict register was occupied")

endmodule

[tb/hostname_or_ipv4_validator_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hostname_or_ipv4_validator: host strings go in word by word
// and every verdict is checked against a typed value or an in-bench model of the host and
// dotted-quad rules. Uses hiv_pkg, the channel interfaces of hiv_if.sv and the validator.
module hostname_or_ipv4_validator_test;
    import hiv_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 16;
    localparam int PHASE_HOSTS    = 2;
    localparam int LONG_CAP       = 72;
    localparam int NO_RAW         = -1;
    localparam int OCTET_CEILING  = 1023;
    localparam bit TYPED          = 1'b1;
    localparam bit PREDICTED      = 1'b0;

    localparam logic [HOST_LEN_W-1:0]  LEN_SATURATED    = '1;
    localparam logic [LABEL_LEN_W-1:0] LABEL_SATURATED  = '1;
    localparam logic [DOT_CNT_W-1:0]   DOTS_SATURATED   = '1;
    localparam logic [OCTET_DIG_W-1:0] DIGITS_SATURATED = '1;

    typedef struct packed {
        logic host_ok;
        logic numeric;
    } verdict_t;

    typedef struct {
        string    head;
        int       raw;
        string    fill;
        int       reps;
        string    tail;
        bit       typed;
        verdict_t verdict;
    } host_case_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [HOST_LEN_W-1:0] cfg_wr_data;

    hiv_char_if    chars_bus();
    hiv_verdict_if verdict_bus();

    hostname_or_ipv4_validator i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_bus),
        .verdict     (verdict_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Model of the string scan.
    logic [HOST_LEN_W-1:0]  host_limit = MAX_LEN_RESET;
    logic [HOST_LEN_W-1:0]  seen_chars;
    logic [CHAR_W-1:0]      last_char;
    logic                   chars_fine;
    logic                   digits_dots_only;
    logic [LABEL_LEN_W-1:0] label_chars;
    logic                   labels_fine;
    logic [DOT_CNT_W-1:0]   dots_seen;
    logic [OCTET_VAL_W-1:0] part_value;
    logic [OCTET_DIG_W-1:0] part_digits;
    logic                   parts_fine;

    verdict_t          pending_verdicts[$];
    bit                have_typed;
    verdict_t          typed_verdict;
    logic [CHAR_W-1:0] host_bytes[$];
    host_case_t        directed_cases[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int hosts_sent    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    function automatic logic digit_char(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic alnum_char(input logic [CHAR_W-1:0] c);
        return digit_char(c)
            || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic label_closes_well();
        return (label_chars >= 1) && (label_chars <= LABEL_LIMIT) && alnum_char(last_char);
    endfunction

    function automatic logic part_closes_well();
        return (part_digits >= 1) && (part_digits <= OCTET_DIGITS_MAX)
            && (part_value <= OCTET_MAX);
    endfunction

    function automatic void restart_scan();
        seen_chars       = '0;
        last_char        = '0;
        chars_fine       = 1'b1;
        digits_dots_only = 1'b1;
        label_chars      = '0;
        labels_fine      = 1'b1;
        dots_seen        = '0;
        part_value       = '0;
        part_digits      = '0;
        parts_fine       = 1'b1;
    endfunction

    function automatic void scan_char(input logic [CHAR_W-1:0] c);
        int next_value;
        if (!alnum_char(c) && (c != CHAR_HYPHEN) && (c != CHAR_DOT))
            chars_fine = 1'b0;
        if ((seen_chars == 0) && ((c == CHAR_HYPHEN) || (c == CHAR_DOT)))
            chars_fine = 1'b0;
        if (seen_chars == LEN_SATURATED)
            chars_fine = 1'b0;
        else
            seen_chars++;
        if (!digit_char(c) && (c != CHAR_DOT))
            digits_dots_only = 1'b0;

        if (c == CHAR_DOT)
        begin
            // A dot closes both the current label and the current quad part.
            if (!label_closes_well())
                labels_fine = 1'b0;
            if (!part_closes_well())
                parts_fine = 1'b0;
            label_chars = '0;
            part_value  = '0;
            part_digits = '0;
            if (dots_seen != DOTS_SATURATED)
                dots_seen++;
        end
        else
        begin
            if ((label_chars == 0) && !alnum_char(c))
                labels_fine = 1'b0;
            if (label_chars == LABEL_SATURATED)
                labels_fine = 1'b0;
            else
                label_chars++;
            if (digit_char(c))
            begin
                next_value = int'(part_value) * 10 + int'(c) - int'(CHAR_ZERO);
                part_value = (next_value > OCTET_CEILING) ? OCTET_VAL_W'(OCTET_CEILING)
                                                          : OCTET_VAL_W'(next_value);
                if (part_digits != DIGITS_SATURATED)
                    part_digits++;
            end
        end
        last_char = c;
    endfunction

    function automatic verdict_t close_host();
        verdict_t v;
        v.host_ok = (seen_chars != 0) && (seen_chars <= host_limit) && chars_fine
                 && (last_char != CHAR_DOT);
        if (digits_dots_only)
            v.host_ok = v.host_ok && parts_fine && part_closes_well()
                     && (dots_seen == QUAD_DOTS);
        else
            v.host_ok = v.host_ok && labels_fine && label_closes_well();
        v.numeric = digits_dots_only;
        restart_scan();
        return v;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_alnum();
        int unsigned r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return CHAR_W'(CHAR_ZERO + r);
        if (r < 36)
            return CHAR_W'(CHAR_UPPER_A + r - 10);
        return CHAR_W'(CHAR_LOWER_A + r - 36);
    endfunction

    function automatic void add_label(input int len);
        for (int k = 0; k < len; k++)
        begin
            if ((k == 0) || (k == len - 1) || ($urandom_range(0, 4) != 0))
                host_bytes.push_back(rand_alnum());
            else
                host_bytes.push_back(CHAR_HYPHEN);
        end
    endfunction

    // A digits value of zero prints the number without leading zeros.
    function automatic void add_decimal(input int unsigned value, input int digits);
        int unsigned scale;
        int          width;
        width = digits;
        if (width == 0)
            width = (value < 10) ? 1 : (value < 100) ? 2 : (value < 1000) ? 3 : 4;
        scale = 1;
        for (int k = 1; k < width; k++)
            scale *= 10;
        for (int k = 0; k < width; k++)
        begin
            host_bytes.push_back(CHAR_W'(CHAR_ZERO + (value / scale) % 10));
            scale /= 10;
        end
    endfunction

    function automatic void add_case(input string head, input bit typed, input logic ok,
                                     input logic numeric, input string fill = "",
                                     input int reps = 0, input string tail = "",
                                     input int raw = NO_RAW);
        host_case_t hc;
        hc.head            = head;
        hc.raw             = raw;
        hc.fill            = fill;
        hc.reps            = reps;
        hc.tail            = tail;
        hc.typed           = typed;
        hc.verdict.host_ok = ok;
        hc.verdict.numeric = numeric;
        directed_cases.push_back(hc);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [CHAR_W-1:0] code, input logic last);
        if ((send_idle_pct != 0) && ($urandom_range(0, 99) < send_idle_pct))
        begin
            chars_bus.valid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        chars_bus.valid         = 1'b1;
        chars_bus.char_code     = code;
        chars_bus.end_of_string = last;
        do
            @(posedge clk);
        while (!chars_bus.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_host();
        foreach (host_bytes[i])
            send_word(host_bytes[i], 1'b0);
        // The character field of the end word is don't-care, so it carries noise.
        send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
        hosts_sent++;
    endtask

    task automatic wait_for_verdicts();
        chars_bus.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [HOST_LEN_W-1:0] value);
        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        host_limit = value;
    endtask

    // Verdict checking and scan of every accepted character word.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (verdict_bus.valid && verdict_bus.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected verdict host_valid=%b numeric_form=%b",
                                 $time, verdict_bus.host_valid, verdict_bus.numeric_form);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if ((verdict_bus.host_valid !== want.host_ok)
                        || (verdict_bus.numeric_form !== want.numeric))
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: verdict mismatch, expected %b/%b, got %b/%b %s",
                                     $time, want.host_ok, want.numeric,
                                     verdict_bus.host_valid, verdict_bus.numeric_form,
                                     "(host_valid/numeric_form)");
                        mismatches++;
                    end
                end
            end

            if (chars_bus.valid && chars_bus.ready)
            begin
                if (chars_bus.end_of_string)
                begin
                    want = close_host();
                    pending_verdicts.push_back(have_typed ? typed_verdict : want);
                end
                else
                    scan_char(chars_bus.char_code);
            end

            if ((chars_bus.valid && chars_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : verdict_sink
        int hold;
        hold              = 0;
        verdict_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                verdict_bus.ready = 1'b0;
            end
            else if ((stall_pct != 0) && ($urandom_range(0, 99) < stall_pct))
            begin
                hold              = pick_gap() - 1;
                verdict_bus.ready = 1'b0;
            end
            else
                verdict_bus.ready = 1'b1;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("** hostname_or_ipv4_validator: FAILED **");
        $finish;
    end

    initial
    begin
        host_case_t            hc;
        int                    first_items;
        int                    first_hosts;
        int                    kind;
        int                    count;
        int                    pick;
        int                    pos;
        logic [HOST_LEN_W-1:0] limit_now;

        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        chars_bus.valid         = 1'b0;
        chars_bus.char_code     = '0;
        chars_bus.end_of_string = 1'b0;
        have_typed              = 1'b0;
        typed_verdict           = '0;
        restart_scan();

        add_case("", TYPED, 1'b0, 1'b1);
        add_case("a", TYPED, 1'b1, 1'b0);
        add_case("example.com", TYPED, 1'b1, 1'b0);
        add_case("Z9-x.Q-7", PREDICTED, 1'b0, 1'b0);
        add_case("0.0.0.0", TYPED, 1'b1, 1'b1);
        add_case("255.255.255.255", TYPED, 1'b1, 1'b1);
        add_case("256.1.1.1", TYPED, 1'b0, 1'b1);
        add_case("1.2.3", TYPED, 1'b0, 1'b1);
        add_case("1.2.3.4.5", TYPED, 1'b0, 1'b1);
        add_case("1234.1.1.1", TYPED, 1'b0, 1'b1);
        add_case("1.2.3.4.", TYPED, 1'b0, 1'b1);
        add_case("", TYPED, 1'b0, 1'b1, "9", 6, ".1.1.1");
        add_case("1.2.3.a", PREDICTED, 1'b0, 1'b0);
        add_case("01.002.3.4", PREDICTED, 1'b0, 1'b0);
        add_case("-abc", TYPED, 1'b0, 1'b0);
        add_case(".abc", TYPED, 1'b0, 1'b0);
        add_case("abc.", TYPED, 1'b0, 1'b0);
        add_case("a..b", TYPED, 1'b0, 1'b0);
        add_case("ab-.cd", TYPED, 1'b0, 1'b0);
        add_case("a_b", TYPED, 1'b0, 1'b0);
        add_case("a", TYPED, 1'b0, 1'b0, "", 0, "b", 0);
        add_case("a", TYPED, 1'b0, 1'b0, "", 0, "b", 255);
        add_case("", TYPED, 1'b1, 1'b0, "a", 63);
        add_case("", TYPED, 1'b0, 1'b0, "a", 64);
        // Runs the label length counter into saturation.
        add_case("x.", TYPED, 1'b0, 1'b0, "a", 130);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 20;
        stall_pct     = 20;
        foreach (directed_cases[i])
        begin
            hc = directed_cases[i];
            host_bytes.delete();
            for (int k = 0; k < hc.head.len(); k++)
                host_bytes.push_back(hc.head[k]);
            if (hc.raw != NO_RAW)
                host_bytes.push_back(CHAR_W'(hc.raw));
            repeat (hc.reps)
                for (int k = 0; k < hc.fill.len(); k++)
                    host_bytes.push_back(hc.fill[k]);
            for (int k = 0; k < hc.tail.len(); k++)
                host_bytes.push_back(hc.tail[k]);
            have_typed    = hc.typed;
            typed_verdict = hc.verdict;
            send_host();
        end
        have_typed = 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       limit_now = LEN_SATURATED;
                1:       limit_now = '0;
                2:       limit_now = HOST_LEN_W'(1);
                3:       limit_now = HOST_LEN_W'(20);
                4:       limit_now = HOST_LEN_W'($urandom_range(2, 1022));
                5:       limit_now = HOST_LEN_W'(64);
                default: limit_now = MAX_LEN_RESET;
            endcase
            write_limit(limit_now);

            // The first phase runs back to back on both sides.
            if (p == 0)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else
            begin
                send_idle_pct = ($urandom_range(0, 2) == 0) ? 5 : $urandom_range(10, 45);
                stall_pct     = ($urandom_range(0, 2) == 0) ? 5 : $urandom_range(10, 45);
            end

            first_items = items_sent;
            first_hosts = hosts_sent;
            while ((items_sent - first_items < PHASE_ITEMS)
                   || (hosts_sent - first_hosts < PHASE_HOSTS))
            begin
                if ($urandom_range(0, 99) < 4)
                    wait_for_verdicts();

                host_bytes.delete();
                kind = $urandom_range(0, 99);
                if (kind < 40)
                begin
                    count = $urandom_range(1, 4);
                    for (int k = 0; k < count; k++)
                    begin
                        if (k != 0)
                            host_bytes.push_back(CHAR_DOT);
                        pick = $urandom_range(0, 99);
                        if (pick < 80)
                            add_label($urandom_range(1, 8));
                        else if (pick < 95)
                            add_label($urandom_range(9, 63));
                        else
                            add_label($urandom_range(60, 70));
                    end
                end
                else if (kind < 75)
                begin
                    count = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
                    for (int k = 0; k < count; k++)
                    begin
                        if (k != 0)
                            host_bytes.push_back(CHAR_DOT);
                        pick = $urandom_range(0, 99);
                        if (pick < 75)
                            add_decimal($urandom_range(0, 255), 0);
                        else if (pick < 85)
                            add_decimal($urandom_range(256, 999), 0);
                        else if (pick < 92)
                            add_decimal($urandom_range(0, 99), 3);
                        else if (pick < 96)
                            add_decimal($urandom_range(0, 9999), 4);
                        // Otherwise the part is left empty.
                    end
                end
                else if (kind < 88)
                begin
                    count = $urandom_range(0, 10);
                    for (int k = 0; k < count; k++)
                    begin
                        pick = $urandom_range(0, 3);
                        if (pick < 2)
                            host_bytes.push_back(CHAR_W'($urandom_range(0, 255)));
                        else if (pick == 2)
                            host_bytes.push_back(($urandom_range(0, 1) != 0) ? CHAR_DOT
                                                                            : CHAR_HYPHEN);
                        else
                            host_bytes.push_back(rand_alnum());
                    end
                end
                else
                begin
                    // Well-formed labels cut to a length right around a small limit;
                    // under a large limit the string is simply kept short.
                    count = int'(host_limit) + int'($urandom_range(0, 2)) - 1;
                    if (count > LONG_CAP)
                        count = $urandom_range(1, LONG_CAP);
                    if (count < 1)
                        count = 1;
                    while (host_bytes.size() < count)
                    begin
                        if (host_bytes.size() != 0)
                            host_bytes.push_back(CHAR_DOT);
                        add_label($urandom_range(1, 63));
                    end
                    while (host_bytes.size() > count)
                        void'(host_bytes.pop_back());
                    if (host_bytes[host_bytes.size() - 1] == CHAR_DOT)
                        host_bytes[host_bytes.size() - 1] = rand_alnum();
                end

                if ($urandom_range(0, 99) < 15)
                begin
                    pick = $urandom_range(0, 5);
                    pos  = (host_bytes.size() == 0) ? 0
                                                    : $urandom_range(0, host_bytes.size() - 1);
                    case (pick)
                        0:
                            if (host_bytes.size() != 0)
                                host_bytes[pos] = CHAR_W'($urandom_range(0, 255));
                        1:
                            if (host_bytes.size() != 0)
                                host_bytes[pos] = CHAR_DOT;
                        2:
                            if (host_bytes.size() != 0)
                                host_bytes[pos] = CHAR_HYPHEN;
                        3:
                            host_bytes.push_front(($urandom_range(0, 1) != 0) ? CHAR_DOT
                                                                             : CHAR_HYPHEN);
                        4:
                            host_bytes.push_back(CHAR_DOT);
                        default:
                            host_bytes.insert(pos, CHAR_DOT);
                    endcase
                end

                send_host();
            end
        end

        wait_for_verdicts();
        repeat (TAIL_CYCLES) @(negedge clk);
        if ((mismatches == 0) && (pending_verdicts.size() == 0))
            $display("** hostname_or_ipv4_validator: PASSED **");
        else
            $display("** hostname_or_ipv4_validator: FAILED **");
        $finish;
    end

endmodule
